>>> hw/rtl/ess_pkg.sv
// Package for the exponential search engine: table sizes, payload structs,
// datapath op codes, status bundle and controller states.
// No dependencies.
package ess_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_WIDTH  = 32;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int NCNT_W  = ADDR_W + 1;  // holds counts, probes and bounds up to the depth
    localparam int CFG_W   = 11;
    localparam int INDEX_W = 10;
    localparam int POS_W   = 10;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic       CMD_WRITE    = 1'b0;
    localparam logic       CMD_SEARCH   = 1'b1;
    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic                         cmd;
        logic        [INDEX_W-1:0]    entry_index;
        logic signed [WORD_WIDTH-1:0] entry_value;
        logic signed [WORD_WIDTH-1:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_START,
        OP_READ_PROBE,
        OP_DOUBLE,
        OP_BSTART_CUR,
        OP_BSTART_DBL,
        OP_BSTEP,
        OP_HIT,
        OP_PUSH
    } t_dp_op;

    typedef struct packed {
        logic cfg_zero;
        logic e_eq;
        logic e_le;
        logic probe_lt_n;
        logic probe2_lt_n;
        logic step_more;
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK0,
        S_GROW,
        S_BIN,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/ess_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ess_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ess_datapath.sv
// Search datapath: table RAM, probe and bound registers, compare logic and
// the output payload register. Depends on ess_pkg and ess_ram.
module ess_datapath (
    input  logic                  i_clk,
    input  ess_pkg::t_dp_op       i_op,
    input  ess_pkg::t_in_item     i_item,
    input  logic [ess_pkg::CFG_W-1:0] i_entry_count,
    output ess_pkg::t_dp_status   o_status,
    output ess_pkg::t_out_item    o_out_item
);
    import ess_pkg::*;

    logic signed [WORD_WIDTH-1:0] r_key;
    logic        [NCNT_W-1:0]     r_n;
    logic        [NCNT_W-1:0]     r_probe;
    logic        [NCNT_W-1:0]     r_lo;
    logic        [NCNT_W-1:0]     r_hi;   // exclusive upper bound
    logic        [ADDR_W-1:0]     r_addr; // address of the word now on rdata
    logic                         r_hit;
    logic        [ADDR_W-1:0]     r_pos;
    t_out_item                    r_out;

    logic signed [WORD_WIDTH-1:0] rdata;
    logic                         ram_we;
    logic                         ram_re;
    logic        [ADDR_W-1:0]     ram_raddr;

    logic [NCNT_W-1:0] cfg_n;
    logic [NCNT_W-1:0] probe2;
    logic [NCNT_W-1:0] init_p;
    logic [NCNT_W-1:0] init_lo;
    logic [NCNT_W-1:0] init_hi;
    logic [NCNT_W-1:0] init_mid;
    logic [NCNT_W-1:0] step_lo;
    logic [NCNT_W-1:0] step_hi;
    logic [NCNT_W-1:0] step_mid;
    logic              e_lt;

    function automatic logic [NCNT_W-1:0] f_mid(input logic [NCNT_W-1:0] lo,
                                                 input logic [NCNT_W-1:0] hi);
        logic [NCNT_W-1:0] span;
        span = hi - lo - NCNT_W'(1);
        return lo + (span >> 1);
    endfunction

    ess_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ADDR_W'(i_item.entry_index)),
        .i_wdata(i_item.entry_value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        cfg_n = (32'(i_entry_count) > 32'(TABLE_DEPTH)) ? NCNT_W'(TABLE_DEPTH)
                                                        : NCNT_W'(i_entry_count);
        probe2 = r_probe << 1;
        init_p = (i_op == OP_BSTART_DBL) ? probe2 : r_probe;
        init_lo = init_p >> 1;
        init_hi = ((init_p < r_n) ? init_p : (r_n - NCNT_W'(1))) + NCNT_W'(1);
        init_mid = f_mid(init_lo, init_hi);

        e_lt = rdata < r_key;
        step_lo = e_lt ? (NCNT_W'(r_addr) + NCNT_W'(1)) : r_lo;
        step_hi = e_lt ? r_hi : NCNT_W'(r_addr);
        step_mid = f_mid(step_lo, step_hi);
    end

    always_comb begin
        o_status.cfg_zero    = (i_entry_count == '0);
        o_status.e_eq        = (rdata == r_key);
        o_status.e_le        = (rdata <= r_key);
        o_status.probe_lt_n  = (r_probe < r_n);
        o_status.probe2_lt_n = (probe2 < r_n);
        o_status.step_more   = (step_lo < step_hi);
    end

    always_comb begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = '0;
        case (i_op)
            OP_WRITE: begin
                ram_we = (32'(i_item.entry_index) < 32'(TABLE_DEPTH));
            end
            OP_START: begin
                ram_re = 1'b1;
            end
            OP_READ_PROBE: begin
                ram_re = 1'b1;
                ram_raddr = ADDR_W'(r_probe);
            end
            OP_DOUBLE: begin
                ram_re = 1'b1;
                ram_raddr = ADDR_W'(probe2);
            end
            OP_BSTART_CUR, OP_BSTART_DBL: begin
                ram_re = 1'b1;
                ram_raddr = ADDR_W'(init_mid);
            end
            OP_BSTEP: begin
                ram_re = 1'b1;
                ram_raddr = ADDR_W'(step_mid);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_key   <= i_item.search_key;
                r_n     <= cfg_n;
                r_probe <= NCNT_W'(1);
                r_addr  <= '0;
                r_hit   <= 1'b0;
                r_pos   <= '0;
            end
            OP_READ_PROBE: begin
                r_addr <= ADDR_W'(r_probe);
            end
            OP_DOUBLE: begin
                r_probe <= probe2;
                r_addr  <= ADDR_W'(probe2);
            end
            OP_BSTART_CUR, OP_BSTART_DBL: begin
                r_lo   <= init_lo;
                r_hi   <= init_hi;
                r_addr <= ADDR_W'(init_mid);
            end
            OP_BSTEP: begin
                r_lo   <= step_lo;
                r_hi   <= step_hi;
                r_addr <= ADDR_W'(step_mid);
            end
            OP_HIT: begin
                r_hit <= 1'b1;
                r_pos <= r_addr;
            end
            OP_PUSH: begin
                r_out.found    <= r_hit;
                r_out.position <= POS_W'(r_pos);
            end
            default: begin
            end
        endcase
    end

    assign o_out_item = r_out;

endmodule

>>> hw/rtl/ess_ctrl.sv
// Search controller: sequences the start, doubling and binary phases and
// owns the input stall and output valid. Depends on ess_pkg.
module ess_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  ess_pkg::t_dp_status  i_status,
    output ess_pkg::t_dp_op      o_op
);
    import ess_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   push;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign push       = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_in_cmd == CMD_SEARCH) begin
                    n_state = i_status.cfg_zero ? S_DONE : S_CHK0;
                end
            end
            S_CHK0: begin
                if (i_status.e_eq) begin
                    n_state = S_DONE;
                end else if (i_status.probe_lt_n) begin
                    n_state = S_GROW;
                end else begin
                    n_state = S_BIN;
                end
            end
            S_GROW: begin
                if (!(i_status.e_le && i_status.probe2_lt_n)) begin
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                if (i_status.e_eq || !i_status.step_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_op = (i_in_cmd == CMD_SEARCH) ? OP_START : OP_WRITE;
                end
            end
            S_CHK0: begin
                if (i_status.e_eq) begin
                    o_op = OP_HIT;
                end else if (i_status.probe_lt_n) begin
                    o_op = OP_READ_PROBE;
                end else begin
                    o_op = OP_BSTART_CUR;
                end
            end
            S_GROW: begin
                if (!i_status.e_le) begin
                    o_op = OP_BSTART_CUR;
                end else if (i_status.probe2_lt_n) begin
                    o_op = OP_DOUBLE;
                end else begin
                    o_op = OP_BSTART_DBL;
                end
            end
            S_BIN: begin
                o_op = i_status.e_eq ? OP_HIT : OP_BSTEP;
            end
            S_DONE: begin
                if (push) begin
                    o_op = OP_PUSH;
                end
            end
            default: begin
                o_op = OP_NONE;
            end
        endcase
    end

    always_comb begin
        if (push) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/exponential_search_engine.sv
// Top level of the exponential search engine: APB register, controller and
// datapath. Depends on ess_pkg, ess_ctrl, ess_datapath.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------
//  in       | in  | i_in_valid / o_in_stall      | t_in_item (cmd, index, value, key)
//  out      | out | o_out_valid / i_out_stall    | t_out_item (found, position)
//  config   | in  | psel, penable, pwrite, pready | entry_count at byte address 0
//
// A write item is written to the table as it is taken. A search makes
// doubling probes and then binary probes, each of them one registered
// table read.
// Reset clears the controller and entry_count; the table is not cleared.
// A finished result waits in the output register; the next item is taken
// while it waits, and a later search holds only if that register is full.
module exponential_search_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ess_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ess_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ess_pkg::PADDR_W-1:0]   paddr,
    input  logic [ess_pkg::PDATA_W-1:0]   pwdata,
    output logic [ess_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ess_pkg::*;

    logic [CFG_W-1:0] r_entry_count;
    logic             cfg_write;
    t_dp_op           op;
    t_dp_status       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_write) begin
            r_entry_count <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) ? PDATA_W'(r_entry_count) : '0;

    ess_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_op       (op)
    );

    ess_datapath u_datapath (
        .i_clk        (i_clk),
        .i_op         (op),
        .i_item       (i_in_data),
        .i_entry_count(r_entry_count),
        .o_status     (status),
        .o_out_item   (o_out_data)
    );

endmodule
